/* src/bm3_pkg.sv */
// ============================================================================
// bm3_pkg: shared definitions for the 3x3 binary morphology block
// Register indexes, default sizes and the structs passed between stages.
// ============================================================================
package bm3_pkg;

    // Default limits and reset values of the frame size
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RST_SIZE       = 1024;
    localparam int MIN_SIZE       = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int MASK_W      = 9;
    localparam logic [MASK_W-1:0] RST_MASK = 9'h1FF;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SE_MASK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT  = 2'd3;

    // Stream payload width
    localparam int TDATA_W = 8;

    // Window bits kept when the window shifts one column left
    localparam logic [8:0] WIN_KEEP = 9'h0DB;

    // Output queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    // Request handed from the counter stage to the window stage
    typedef struct packed {
        logic valid;
        logic emit;
        logic drain;
        logic px;
        logic ls_zero;
        logic row_top_ok;
        logic row_bot_ok;
        logic col_left_ok;
        logic col_right_ok;
        logic frame_end;
    } s1_ctrl_t;

    // Result handed from the window stage to the output queue
    typedef struct packed {
        logic valid;
        logic result;
        logic frame_end;
    } res_t;

endpackage

/* src/bm3_line_ram.sv */
// ============================================================================
// bm3_line_ram: two-row line store
// One write port and one registered read port.
// Bit 0 holds the previous row, bit 1 the row before it.
// ============================================================================
module bm3_line_ram #(
    parameter int DEPTH = bm3_pkg::DEF_MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [1:0]               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [1:0]               wr_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    // Write back the updated column pair
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bm3_ctrl.sv */
// ============================================================================
// bm3_ctrl: frame counters and line store addressing
// Tracks input and output positions, decides per request whether it is a
// pixel, an ignored flush or a drain step, and issues the line store read.
// ============================================================================
module bm3_ctrl #(
    parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bm3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bm3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bm3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_px,
    input  logic                             s_flush,
    output logic                             s_tready,
    input  logic [bm3_pkg::FIFO_CNT_W-1:0]   fifo_count,
    output logic                             rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    output bm3_pkg::s1_ctrl_t                s1,
    output logic [$clog2(MAX_WIDTH)-1:0]     s1_addr
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W  = (MAX_WIDTH < bm3_pkg::RST_SIZE) ? MAX_WIDTH : bm3_pkg::RST_SIZE;
    localparam int RST_H  = (MAX_HEIGHT < bm3_pkg::RST_SIZE) ? MAX_HEIGHT : bm3_pkg::RST_SIZE;

    logic [COL_W-1:0]  w_reg, w_next;
    logic [ROW_W-1:0]  h_reg, h_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    bm3_pkg::s1_ctrl_t s1_reg, s1_next;
    logic [ADDR_W-1:0] s1_addr_reg;

    logic                      accept;
    logic                      draining;
    logic                      emit;
    logic                      act;
    logic                      in_last_col;
    logic                      out_last_col;
    logic                      out_last_row;
    logic                      fe;
    logic                      restart;
    logic [bm3_pkg::FIFO_CNT_W:0] occupancy;

    // Hold off input while the queue could not take one more result
    assign occupancy = {1'b0, fifo_count}
                     + (bm3_pkg::FIFO_CNT_W + 1)'(s1_reg.valid & s1_reg.emit);
    assign s_tready  = occupancy <= (bm3_pkg::FIFO_CNT_W + 1)'(bm3_pkg::FIFO_DEPTH - 1);
    assign accept    = s_tvalid & s_tready;

    // Classify the request
    assign draining     = in_row_reg >= h_reg;
    assign act          = accept & (draining | ~s_flush);
    assign emit         = draining
                        | (in_row_reg >= ROW_W'(2))
                        | ((in_row_reg == ROW_W'(1)) & (in_col_reg != '0));
    assign in_last_col  = in_col_reg == (w_reg - COL_W'(1));
    assign out_last_col = out_col_reg == (w_reg - COL_W'(1));
    assign out_last_row = out_row_reg == (h_reg - ROW_W'(1));
    assign fe           = out_last_col & out_last_row;

    // Read the line store at the input column
    assign rd_en   = act;
    assign rd_addr = in_col_reg[ADDR_W-1:0];

    // Decode size writes with clamping
    always_comb
    begin
        w_next  = w_reg;
        h_next  = h_reg;
        restart = 1'b0;
        if (cfg_we && (cfg_index == bm3_pkg::REG_WIDTH))
        begin
            restart = 1'b1;
            if (32'(cfg_data) < 32'(bm3_pkg::MIN_SIZE))
                w_next = COL_W'(bm3_pkg::MIN_SIZE);
            else if (32'(cfg_data) > 32'(MAX_WIDTH))
                w_next = COL_W'(MAX_WIDTH);
            else
                w_next = COL_W'(cfg_data);
        end
        if (cfg_we && (cfg_index == bm3_pkg::REG_HEIGHT))
        begin
            restart = 1'b1;
            if (32'(cfg_data) < 32'(bm3_pkg::MIN_SIZE))
                h_next = ROW_W'(bm3_pkg::MIN_SIZE);
            else if (32'(cfg_data) > 32'(MAX_HEIGHT))
                h_next = ROW_W'(MAX_HEIGHT);
            else
                h_next = ROW_W'(cfg_data);
        end
    end

    // Advance the input and output positions
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (act)
        begin
            if (draining || !in_last_col)
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            else
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            if (emit)
            begin
                if (fe)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    // Build the request for the window stage
    always_comb
    begin
        s1_next.valid        = act;
        s1_next.emit         = emit;
        s1_next.drain        = draining;
        s1_next.px           = s_px;
        s1_next.ls_zero      = draining & (in_col_reg >= w_reg);
        s1_next.row_top_ok   = out_row_reg != '0;
        s1_next.row_bot_ok   = ~out_last_row;
        s1_next.col_left_ok  = out_col_reg != '0;
        s1_next.col_right_ok = ~out_last_col;
        s1_next.frame_end    = emit & fe;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= COL_W'(RST_W);
            h_reg       <= ROW_W'(RST_H);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_reg      <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_reg      <= s1_next;
        end
    end

    // Carry the column address for the write back
    always_ff @(posedge clk)
    begin
        if (act)
        begin
            s1_addr_reg <= in_col_reg[ADDR_W-1:0];
        end
    end

    assign s1      = s1_reg;
    assign s1_addr = s1_addr_reg;

endmodule

/* src/bm3_window.sv */
// ============================================================================
// bm3_window: 3x3 window and morphology result
// Merges line store data with the new pixel, writes the column pair back,
// shifts the window and evaluates dilation or erosion.
// ============================================================================
module bm3_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bm3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bm3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  bm3_pkg::s1_ctrl_t               s1,
    input  logic [1:0]                      rd_data,
    output logic                            wr_en,
    output logic [1:0]                      wr_data,
    output bm3_pkg::res_t                   res
);

    logic                        mode_reg;
    logic [bm3_pkg::MASK_W-1:0]  mask_reg;
    logic [8:0]                  win_reg, win_next;

    logic [1:0] ls;
    logic       bot;
    logic       centre;
    logic [8:0] ok;
    logic [8:0] mask_rev;
    logic       dil;
    logic       ero;

    // Drop line data past the row end and the pixel while draining
    assign ls  = s1.ls_zero ? 2'b00 : rd_data;
    assign bot = s1.drain ? 1'b0 : s1.px;

    // Shift the window and insert the new right column
    assign win_next = ((win_reg >> 1) & bm3_pkg::WIN_KEEP)
                    | {bot, 2'b00, ls[0], 2'b00, ls[1], 2'b00};
    assign centre   = win_next[4];

    // Mark window cells that lie inside the image
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ok[i*3+j] = ((i != 0) || s1.row_top_ok) && ((i != 2) || s1.row_bot_ok)
                         && ((j != 0) || s1.col_left_ok) && ((j != 2) || s1.col_right_ok);
            end
        end
        for (int k = 0; k < 9; k++)
        begin
            mask_rev[k] = mask_reg[8-k];
        end
    end

    // Dilation uses the reflected mask, erosion the mask as written
    assign dil = centre | (|(mask_rev & ok & win_next));
    assign ero = centre & (&(~mask_reg | ~ok | win_next));

    assign res.valid     = s1.valid & s1.emit;
    assign res.result    = mode_reg ? ero : dil;
    assign res.frame_end = s1.frame_end;

    // Write back the shifted column pair on pixel requests
    assign wr_en   = s1.valid & ~s1.drain;
    assign wr_data = {ls[0], s1.px};

    // Mode and mask registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            mask_reg <= bm3_pkg::RST_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bm3_pkg::REG_MODE:    mode_reg <= cfg_data[0];
                bm3_pkg::REG_SE_MASK: mask_reg <= cfg_data[bm3_pkg::MASK_W-1:0];
                default:              ;
            endcase
        end
    end

    // Window register: clear on frame end or size change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (cfg_we && ((cfg_index == bm3_pkg::REG_WIDTH)
                         || (cfg_index == bm3_pkg::REG_HEIGHT)))
        begin
            win_reg <= '0;
        end
        else if (s1.valid)
        begin
            win_reg <= s1.frame_end ? 9'b0 : win_next;
        end
    end

endmodule

/* src/bm3_out_fifo.sv */
// ============================================================================
// bm3_out_fifo: three-entry result queue
// Decouples the result stage from a stalling receiver.
// ============================================================================
module bm3_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bm3_pkg::res_t                  push,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           m_result,
    output logic                           m_frame_end,
    output logic [bm3_pkg::FIFO_CNT_W-1:0] count
);

    logic [1:0]                       entry_q [bm3_pkg::FIFO_DEPTH];
    logic [bm3_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bm3_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bm3_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                             pop;

    function automatic logic [bm3_pkg::FIFO_PTR_W-1:0] ptr_inc(
        input logic [bm3_pkg::FIFO_PTR_W-1:0] p);
        if (p == bm3_pkg::FIFO_PTR_W'(bm3_pkg::FIFO_DEPTH - 1))
            return '0;
        else
            return p + bm3_pkg::FIFO_PTR_W'(1);
    endfunction

    assign m_tvalid    = count_reg != '0;
    assign pop         = m_tvalid & m_tready;
    assign m_result    = entry_q[rd_ptr_reg][1];
    assign m_frame_end = entry_q[rd_ptr_reg][0];
    assign count       = count_reg;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + bm3_pkg::FIFO_CNT_W'(push.valid)
                    - bm3_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming result
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_q[wr_ptr_reg] <= {push.result, push.frame_end};
        end
    end

endmodule

/* src/binary_morphology_3x3_top.sv */
// ============================================================================
// binary_morphology_3x3_top: 3x3 binary dilation / erosion on a pixel stream
// Pixels enter in raster order on the slave stream; results leave on the
// master stream with tlast on the last pixel of the frame.
// ============================================================================
// Usage:
//   s_tdata[0] carries the pixel (1 = black), s_tuser marks a flush request.
//   Flush requests are dropped while pixels of the frame are still expected;
//   after the last pixel, width+1 further requests drain the final results.
//   The first width+1 pixels of a frame produce no result.
//   Write mode, mask, width and height on the cfg port only while idle; a
//   size write restarts the frame.
//   Throughput: one request per cycle while s_tready is high, set by the
//   single read port of the line store, read in the accept cycle and written
//   back the next cycle. m_tvalid rises after the accepted request is registered
//   for the window stage and its result is written into the output queue.
//   A three-entry output queue absorbs receiver stalls; s_tready drops only
//   when that queue could overflow.
//   Reset clears counters, window and registers (mode dilation, full mask,
//   1024 x 1024 or the maximum size if smaller); the line store needs no clearing.
// ============================================================================
module binary_morphology_3x3_top #(
    parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bm3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bm3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bm3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bm3_pkg::TDATA_W-1:0]     s_tdata,   // [0] pixel_black, rest zero
    input  logic                            s_tuser,   // [0] flush
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bm3_pkg::TDATA_W-1:0]     m_tdata,   // [0] result_black, rest zero
    output logic                            m_tlast
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    bm3_pkg::s1_ctrl_t                s1;
    bm3_pkg::res_t                    res;
    logic [ADDR_W-1:0]                rd_addr;
    logic [ADDR_W-1:0]                s1_addr;
    logic                             rd_en;
    logic [1:0]                       rd_data;
    logic                             wr_en;
    logic [1:0]                       wr_data;
    logic [bm3_pkg::FIFO_CNT_W-1:0]   fifo_count;
    logic                             m_result;

    bm3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_px       (s_tdata[0]),
        .s_flush    (s_tuser),
        .s_tready   (s_tready),
        .fifo_count (fifo_count),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .s1         (s1),
        .s1_addr    (s1_addr)
    );

    bm3_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (wr_data)
    );

    bm3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s1        (s1),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .res       (res)
    );

    bm3_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (res),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (m_result),
        .m_frame_end (m_tlast),
        .count       (fifo_count)
    );

    assign m_tdata = {(bm3_pkg::TDATA_W - 1)'(0), m_result};

endmodule
